// ----- rtl/frame_destuff_check_sequence_top_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef FRAME_DESTUFF_CHECK_SEQUENCE_TOP_MACROS_SVH
`define FRAME_DESTUFF_CHECK_SEQUENCE_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FDCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be seen outside reset.
`define FDCS_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- rtl/fdcs_pkg.sv -----
// Shared types, codes and constants of the frame receiver.
package fdcs_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned SIZE_W    = 7;
   localparam int unsigned SEQ_W     = 5;
   localparam int unsigned TYPE_W    = 4;
   localparam int unsigned VERD_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // Stuffing bytes
   localparam logic [BYTE_W-1:0] ESC_A      = 8'h88;
   localparam logic [BYTE_W-1:0] ESC_B      = 8'h81;
   localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'hff;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NACK_TYPE    = 2'd1;

   localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd126;
   localparam logic [TYPE_W-1:0] NACK_TYPE_RST    = 4'd1;

   // Verdict codes
   localparam logic [VERD_W-1:0] VERD_ACCEPT    = 2'd0;
   localparam logic [VERD_W-1:0] VERD_CSUM_ERR  = 2'd1;
   localparam logic [VERD_W-1:0] VERD_OLD_SEQ   = 2'd2;
   localparam logic [VERD_W-1:0] VERD_NACK_RCVD = 2'd3;

   // Token kinds passed from front to back
   localparam logic [1:0] TOK_DATA      = 2'd0;
   localparam logic [1:0] TOK_START_OK  = 2'd1;
   localparam logic [1:0] TOK_START_BAD = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data;
   } token_type;

   // Token queue sizing
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic is_escape(input logic [BYTE_W-1:0] b);
      return (b == ESC_A) || (b == ESC_B);
   endfunction

endpackage

// ----- rtl/fdcs_front.sv -----
// Front end: start-marker check and byte destuffing into tokens.
module fdcs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [fdcs_pkg::BYTE_W-1:0]   wire_byte,
   input  logic                          frame_start,
   input  logic [fdcs_pkg::BYTE_W-1:0]   start_marker,
   output logic                          push,
   output fdcs_pkg::token_type           push_tok
);
   import fdcs_pkg::*;

   logic esc_ff;
   logic esc_in;

   // Classify the accepted byte; drop a stuffed 0xff after an escape
   always_comb begin
      push          = 1'b0;
      push_tok.kind = TOK_DATA;
      push_tok.data = wire_byte;
      esc_in        = esc_ff;
      if (accept) begin
         if (frame_start) begin
            push = 1'b1;
            if (wire_byte == start_marker) begin
               push_tok.kind = TOK_START_OK;
               esc_in        = is_escape(wire_byte);
            end else begin
               push_tok.kind = TOK_START_BAD;
               esc_in        = 1'b0;
            end
         end else if (esc_ff && (wire_byte == STUFF_BYTE)) begin
            esc_in = 1'b0;
         end else begin
            esc_in = is_escape(wire_byte);
            push   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else begin
         esc_ff <= esc_in;
      end
   end

endmodule

// ----- rtl/fdcs_queue.sv -----
// Small token queue between front and back.
`include "frame_destuff_check_sequence_top_macros.svh"
module fdcs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fdcs_pkg::token_type   push_tok,
   input  logic                  pop,
   output fdcs_pkg::token_type   pop_tok,
   output logic                  nonempty,
   output logic                  full
);
   import fdcs_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   token_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign nonempty = (count_ff != '0);
   assign full     = (count_ff == CNT_FULL);
   assign pop_tok  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

   `FDCS_ASSERT(a_count_bound, count_ff <= CNT_FULL, "queue count above depth")
   `FDCS_ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into full queue")
   `FDCS_ASSERT_NEVER(a_no_underflow, pop && !nonempty, "pop from empty queue")

endmodule

// ----- rtl/fdcs_back.sv -----
// Back end: header parse, checksum, sequence check and result register.
`include "frame_destuff_check_sequence_top_macros.svh"
module fdcs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tok_valid,
   input  fdcs_pkg::token_type           tok,
   output logic                          pop,
   input  logic [fdcs_pkg::TYPE_W-1:0]   nack_type_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_result_kind,
   output logic [fdcs_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic [fdcs_pkg::VERD_W-1:0]   rsp_verdict,
   output logic                          rsp_sequence_ahead,
   output logic [fdcs_pkg::SEQ_W-1:0]    rsp_frame_sequence,
   output logic [fdcs_pkg::TYPE_W-1:0]   rsp_frame_type,
   output logic [fdcs_pkg::SIZE_W-1:0]   rsp_frame_size,
   output logic                          rsp_last
);
   import fdcs_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_HDR2 = 3'd2;
   localparam logic [2:0] PH_CSUM = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   logic [2:0]        phase_ff,   phase_in;
   logic [SEQ_W-1:0]  exp_seq_ff, exp_seq_in;
   logic [SIZE_W-1:0] size_ff,    size_in;
   logic [SEQ_W-1:0]  seq_ff,     seq_in;
   logic [TYPE_W-1:0] type_ff,    type_in;
   logic [BYTE_W-1:0] rcsum_ff,   rcsum_in;
   logic [BYTE_W-1:0] sum_ff,     sum_in;
   logic [SIZE_W-1:0] cnt_ff,     cnt_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff,  out_kind_in;
   logic [BYTE_W-1:0] out_pay_ff,   out_pay_in;
   logic [VERD_W-1:0] out_verd_ff,  out_verd_in;
   logic              out_ahead_ff, out_ahead_in;
   logic [SEQ_W-1:0]  out_seq_ff;
   logic [TYPE_W-1:0] out_type_ff;
   logic [SIZE_W-1:0] out_size_ff;

   logic [BYTE_W-1:0] sum_add;
   logic [SIZE_W-1:0] cnt_inc;
   logic [BYTE_W-1:0] fin_sum, fin_ref;
   logic [VERD_W-1:0] fin_verd;
   logic              fin_ahead, fin_adv;

   // Take a token when the result slot is free or draining
   assign pop = tok_valid && (!out_valid_ff || !rsp_stall);

   assign sum_add = sum_ff + tok.data;
   assign cnt_inc = cnt_ff + 1'b1;

   // End-of-frame verdict
   always_comb begin
      fin_sum   = (phase_ff == PH_CSUM) ? sum_ff : sum_add;
      fin_ref   = (phase_ff == PH_CSUM) ? tok.data : rcsum_ff;
      fin_verd  = VERD_ACCEPT;
      fin_ahead = 1'b0;
      fin_adv   = 1'b0;
      if (fin_sum != fin_ref) begin
         fin_verd = VERD_CSUM_ERR;
      end else if (seq_ff < exp_seq_ff) begin
         fin_verd = VERD_OLD_SEQ;
      end else begin
         fin_ahead = (seq_ff > exp_seq_ff);
         if (type_ff == nack_type_code) begin
            fin_verd = VERD_NACK_RCVD;
         end else begin
            fin_adv = 1'b1;
         end
      end
   end

   // Parser step and result register
   always_comb begin
      phase_in     = phase_ff;
      exp_seq_in   = exp_seq_ff;
      size_in      = size_ff;
      seq_in       = seq_ff;
      type_in      = type_ff;
      rcsum_in     = rcsum_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_pay_in   = out_pay_ff;
      out_verd_in  = out_verd_ff;
      out_ahead_in = out_ahead_ff;
      if (pop) begin
         out_valid_in = 1'b0;
         case (tok.kind)
            TOK_START_OK: begin
               phase_in = PH_HDR1;
               sum_in   = '0;
               cnt_in   = '0;
            end
            TOK_START_BAD: begin
               phase_in = PH_IDLE;
            end
            TOK_DATA: begin
               case (phase_ff)
                  PH_HDR1: begin
                     size_in  = tok.data[BYTE_W-1:1];
                     seq_in   = {tok.data[0], 4'b0000};
                     sum_in   = sum_add;
                     phase_in = PH_HDR2;
                  end
                  PH_HDR2: begin
                     seq_in   = {seq_ff[SEQ_W-1], tok.data[BYTE_W-1:4]};
                     type_in  = tok.data[TYPE_W-1:0];
                     sum_in   = sum_add;
                     phase_in = PH_CSUM;
                  end
                  PH_CSUM: begin
                     rcsum_in = tok.data;
                     cnt_in   = '0;
                     if (size_ff == '0) begin
                        phase_in     = PH_IDLE;
                        out_valid_in = 1'b1;
                        out_kind_in  = 1'b1;
                        out_pay_in   = '0;
                        out_verd_in  = fin_verd;
                        out_ahead_in = fin_ahead;
                        if (fin_adv) begin
                           exp_seq_in = exp_seq_ff + 1'b1;
                        end
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     sum_in       = sum_add;
                     cnt_in       = cnt_inc;
                     out_valid_in = 1'b1;
                     out_pay_in   = tok.data;
                     if (cnt_inc == size_ff) begin
                        phase_in     = PH_IDLE;
                        out_kind_in  = 1'b1;
                        out_verd_in  = fin_verd;
                        out_ahead_in = fin_ahead;
                        if (fin_adv) begin
                           exp_seq_in = exp_seq_ff + 1'b1;
                        end
                     end else begin
                        out_kind_in  = 1'b0;
                        out_verd_in  = VERD_ACCEPT;
                        out_ahead_in = 1'b0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         exp_seq_ff   <= '0;
         size_ff      <= '0;
         seq_ff       <= '0;
         type_ff      <= '0;
         rcsum_ff     <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         exp_seq_ff   <= exp_seq_in;
         size_ff      <= size_in;
         seq_ff       <= seq_in;
         type_ff      <= type_in;
         rcsum_ff     <= rcsum_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload, no reset
   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_pay_ff   <= out_pay_in;
      out_verd_ff  <= out_verd_in;
      out_ahead_ff <= out_ahead_in;
      if (pop && out_valid_in) begin
         out_seq_ff  <= seq_ff;
         out_type_ff <= type_ff;
         out_size_ff <= size_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_payload_byte   = out_pay_ff;
   assign rsp_verdict        = out_verd_ff;
   assign rsp_sequence_ahead = out_ahead_ff;
   assign rsp_frame_sequence = out_seq_ff;
   assign rsp_frame_type     = out_type_ff;
   assign rsp_frame_size     = out_size_ff;
   assign rsp_last           = out_kind_ff;

   `FDCS_ASSERT(a_payload_clean,
      (out_valid_ff && !out_kind_ff) |-> (out_verd_ff == VERD_ACCEPT && !out_ahead_ff),
      "payload item carries verdict")
   `FDCS_ASSERT_NEVER(a_ahead_on_reject,
      out_valid_ff && out_ahead_ff && (out_verd_ff == VERD_CSUM_ERR || out_verd_ff == VERD_OLD_SEQ),
      "sequence_ahead on rejected frame")
   `FDCS_ASSERT_NEVER(a_no_take_stalled, pop && out_valid_ff && rsp_stall,
      "token taken while result stalled")

endmodule

// ----- rtl/frame_destuff_check_sequence_top.sv -----
// Top level of the byte-stuffed frame receiver with checksum and sequence check.
//
//   channel | ports                        | direction | handshake
//   --------+------------------------------+-----------+--------------------
//   req     | wire_byte, frame_start       | in        | req_valid / req_stall
//   rsp     | kind, payload, verdict, hdr  | out       | rsp_valid / rsp_stall
//   csr     | index, wdata                 | in        | csr_valid / csr_ready
//
// One byte is accepted per cycle while req_stall is low.
// Throughput is set by the parser: one token a cycle unless a result is stalled.
// req_stall rises only when the four-entry token queue is full.
// rsp_stall holds the result register; the queue absorbs bytes meanwhile.
// Synchronous reset clears parser, sequence and result-valid state, sets CSRs.
module frame_destuff_check_sequence_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fdcs_pkg::BYTE_W-1:0]      req_wire_byte,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_result_kind,
   output logic [fdcs_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic [fdcs_pkg::VERD_W-1:0]      rsp_verdict,
   output logic                             rsp_sequence_ahead,
   output logic [fdcs_pkg::SEQ_W-1:0]       rsp_frame_sequence,
   output logic [fdcs_pkg::TYPE_W-1:0]      rsp_frame_type,
   output logic [fdcs_pkg::SIZE_W-1:0]      rsp_frame_size,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fdcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdcs_pkg::BYTE_W-1:0]      csr_wdata
);
   import fdcs_pkg::*;

   logic [BYTE_W-1:0] start_marker_ff;
   logic [TYPE_W-1:0] nack_type_ff;

   logic      accept;
   logic      push;
   token_type push_tok;
   logic      pop;
   token_type pop_tok;
   logic      q_nonempty;
   logic      q_full;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         nack_type_ff    <= NACK_TYPE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_NACK_TYPE:    nack_type_ff    <= csr_wdata[TYPE_W-1:0];
            default: begin
               start_marker_ff <= start_marker_ff;
            end
         endcase
      end
   end

   fdcs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .wire_byte    (req_wire_byte),
      .frame_start  (req_frame_start),
      .start_marker (start_marker_ff),
      .push         (push),
      .push_tok     (push_tok)
   );

   fdcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .pop      (pop),
      .pop_tok  (pop_tok),
      .nonempty (q_nonempty),
      .full     (q_full)
   );

   fdcs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .tok_valid          (q_nonempty),
      .tok                (pop_tok),
      .pop                (pop),
      .nack_type_code     (nack_type_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_verdict        (rsp_verdict),
      .rsp_sequence_ahead (rsp_sequence_ahead),
      .rsp_frame_sequence (rsp_frame_sequence),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_frame_size     (rsp_frame_size),
      .rsp_last           (rsp_last)
   );

endmodule
